### hw/rtl/rhc_pkg.sv
// Package for the RGB/HSV color converter: fixed-point constants, request
// codes, item types and the component saturate function.
// No dependencies.
`default_nettype none
package rhc_pkg;

	localparam int FRAC_BITS  = 15;
	localparam int FIELD_W    = 16;
	localparam int CW         = FRAC_BITS + 1;
	localparam int DEN_W      = FRAC_BITS + 4;
	localparam int DIV_STAGES = 4;
	localparam int DIV_BPS    = (CW + DIV_STAGES - 1) / DIV_STAGES;
	localparam int DIV_TOT    = DIV_STAGES * DIV_BPS;
	localparam int NUM_W      = DEN_W + DIV_TOT;

	localparam logic [CW-1:0]     ONE      = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [2*CW-1:0]   HALF_P   = (2*CW)'(1) << (FRAC_BITS - 1);

	localparam logic [1:0] REQ_PASS    = 2'd0;
	localparam logic [1:0] REQ_HSV2RGB = 2'd1;
	localparam logic [1:0] REQ_RGB2HSV = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [FIELD_W-1:0] in_first;
		logic [FIELD_W-1:0] in_second;
		logic [FIELD_W-1:0] in_third;
		logic [FIELD_W-1:0] in_alpha;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] out_first;
		logic [FIELD_W-1:0] out_second;
		logic [FIELD_W-1:0] out_third;
		logic [FIELD_W-1:0] out_alpha;
	} out_item_t;

	function automatic logic [CW-1:0] sat_one(input logic [FIELD_W-1:0] x);
		logic [CW-1:0] r;
		if (x > FIELD_W'(ONE)) begin
			r = ONE;
		end else begin
			r = CW'(x);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/rhc_div_pipe.sv
// Pipelined restoring divider, DIV_BPS quotient bits per register stage.
// One division accepted every cycle. Uses rhc_pkg.
`default_nettype none
module rhc_div_pipe (
	input  wire logic                      clk,
	input  wire logic [rhc_pkg::NUM_W-1:0] num,
	input  wire logic [rhc_pkg::DEN_W-1:0] den,
	output logic      [rhc_pkg::CW-1:0]    quo
);
	import rhc_pkg::*;

	logic [DEN_W-1:0]   rem_s [DIV_STAGES+1];
	logic [DIV_TOT-1:0] nlo_s [DIV_STAGES+1];
	logic [DEN_W-1:0]   den_s [DIV_STAGES+1];
	logic [CW-1:0]      quo_s [DIV_STAGES+1];

	assign rem_s[0] = num[NUM_W-1:DIV_TOT];
	assign nlo_s[0] = num[DIV_TOT-1:0];
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DEN_W-1:0]   rem_n;
		logic [DIV_TOT-1:0] nlo_n;
		logic [CW-1:0]      quo_n;

		always_comb begin : step
			logic [DEN_W:0] r2;
			rem_n = rem_s[k];
			nlo_n = nlo_s[k];
			quo_n = quo_s[k];
			for (int j = 0; j < DIV_BPS; j++) begin
				r2    = {rem_n, nlo_n[DIV_TOT-1]};
				nlo_n = nlo_n << 1;
				if (r2 >= {1'b0, den_s[k]}) begin
					r2    = r2 - {1'b0, den_s[k]};
					quo_n = {quo_n[CW-2:0], 1'b1};
				end else begin
					quo_n = {quo_n[CW-2:0], 1'b0};
				end
				rem_n = r2[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= rem_n;
			nlo_s[k+1] <= nlo_n;
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= quo_n;
		end
	end

	assign quo = quo_s[DIV_STAGES];

endmodule
`default_nettype wire

### hw/rtl/rgb_hsv_color_converter.sv
// RGB/HSV color converter, top level: seven-stage pipeline with two
// pipelined dividers for hue and saturation. Uses rhc_pkg, rhc_div_pipe.
//
// One item is taken every clock (busy is always low); its result appears on
// result with done high from the stage-7 output register. The pipeline is
// two stages of operand preparation, the two 4-stage dividers and the output
// register. The receiver cannot stall and no result is ever held back.
`default_nettype none
module rgb_hsv_color_converter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire rhc_pkg::in_item_t  pixel,
	output logic                    done,
	output rhc_pkg::out_item_t      result
);
	import rhc_pkg::*;

	localparam int NW = CW + 3;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	in_item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6;
	logic [1:0] req_s7;

	// stage 1
	logic [CW-1:0] r_c, g_c, b_c;
	logic [CW-1:0] r_s1, g_s1, b_s1, mx_s1, mn_s1;
	logic [FRAC_BITS-1:0] h_s1;
	logic [2*CW-1:0] vs_s1;

	assign r_c = sat_one(pixel.in_first);
	assign g_c = sat_one(pixel.in_second);
	assign b_c = sat_one(pixel.in_third);

	always_ff @(posedge clk) begin
		it_s1 <= pixel;
		r_s1  <= r_c;
		g_s1  <= g_c;
		b_s1  <= b_c;
		mx_s1 <= (r_c > g_c) ? ((b_c > r_c) ? b_c : r_c) : ((b_c > g_c) ? b_c : g_c);
		mn_s1 <= (r_c < g_c) ? ((b_c < r_c) ? b_c : r_c) : ((b_c < g_c) ? b_c : g_c);
		h_s1  <= pixel.in_first[FRAC_BITS-1:0];
		vs_s1 <= (2*CW)'(g_c) * (2*CW)'(b_c);
	end

	// stage 2
	logic [CW-1:0] d_c;
	logic [NW-1:0] d6_c, n_c;
	logic [2*CW-1:0] csum_c;
	logic [FRAC_BITS+2:0] h6_c;
	logic [CW-1:0] f_c;
	logic [NUM_W-1:0] hnum_s2, snum_s2;
	logic [DEN_W-1:0] hden_s2, sden_s2;
	logic [CW-1:0] mx_s2, v_s2, c_s2, t_s2;
	logic [2:0] sec_s2;
	logic dz_s2, mz_s2;

	assign d_c  = mx_s1 - mn_s1;
	assign d6_c = NW'(d_c) * NW'(6);
	always_comb begin
		if (mx_s1 == r_s1) begin
			if (g_s1 >= b_s1) begin
				n_c = NW'(g_s1) - NW'(b_s1);
			end else begin
				n_c = d6_c - (NW'(b_s1) - NW'(g_s1));
			end
		end else if (mx_s1 == g_s1) begin
			n_c = {d_c, 1'b0} + NW'(b_s1) - NW'(r_s1);
		end else begin
			n_c = {d_c, 2'b00} + NW'(r_s1) - NW'(g_s1);
		end
	end
	assign csum_c = vs_s1 + HALF_P;
	assign h6_c   = (FRAC_BITS+3)'(h_s1) * (FRAC_BITS+3)'(6);
	assign f_c    = {1'b0, h6_c[FRAC_BITS-1:0]};

	always_ff @(posedge clk) begin
		it_s2   <= it_s1;
		hnum_s2 <= NUM_W'({n_c, {(FRAC_BITS+1){1'b0}}}) + NUM_W'(d6_c);
		hden_s2 <= DEN_W'({d6_c, 1'b0});
		snum_s2 <= NUM_W'({d_c, {(FRAC_BITS+1){1'b0}}}) + NUM_W'(mx_s1);
		sden_s2 <= DEN_W'({mx_s1, 1'b0});
		dz_s2   <= (d_c == '0);
		mz_s2   <= (mx_s1 == '0);
		mx_s2   <= mx_s1;
		v_s2    <= b_s1;
		c_s2    <= csum_c[FRAC_BITS+CW-1:FRAC_BITS];
		sec_s2  <= h6_c[FRAC_BITS+2:FRAC_BITS];
		t_s2    <= h6_c[FRAC_BITS] ? (ONE - f_c) : f_c;
	end

	logic [CW-1:0] hq, sq;

	rhc_div_pipe u_hue_div (.clk(clk), .num(hnum_s2), .den(hden_s2), .quo(hq));
	rhc_div_pipe u_sat_div (.clk(clk), .num(snum_s2), .den(sden_s2), .quo(sq));

	// stages 3..6, HSV to RGB arm and sideband
	logic [CW-1:0] mx_s3, mx_s4, mx_s5, mx_s6;
	logic dz_s3, dz_s4, dz_s5, dz_s6, mz_s3, mz_s4, mz_s5, mz_s6;
	logic [CW-1:0] v_s3, c_s3, v_s4, m_s4, xm_s4;
	logic [2:0] sec_s3, sec_s4;
	logic [2*CW-1:0] ct_s3, xs_c;
	logic [CW-1:0] o0_s5, o1_s5, o2_s5, o0_s6, o1_s6, o2_s6;

	assign xs_c = ct_s3 + HALF_P;

	always_ff @(posedge clk) begin
		it_s3  <= it_s2;
		mx_s3  <= mx_s2;
		dz_s3  <= dz_s2;
		mz_s3  <= mz_s2;
		v_s3   <= v_s2;
		c_s3   <= c_s2;
		sec_s3 <= sec_s2;
		ct_s3  <= (2*CW)'(c_s2) * (2*CW)'(t_s2);

		it_s4  <= it_s3;
		mx_s4  <= mx_s3;
		dz_s4  <= dz_s3;
		mz_s4  <= mz_s3;
		v_s4   <= v_s3;
		sec_s4 <= sec_s3;
		m_s4   <= v_s3 - c_s3;
		xm_s4  <= xs_c[FRAC_BITS+CW-1:FRAC_BITS] + (v_s3 - c_s3);

		it_s5 <= it_s4;
		mx_s5 <= mx_s4;
		dz_s5 <= dz_s4;
		mz_s5 <= mz_s4;
		case (sec_s4)
			3'd0: begin
				o0_s5 <= v_s4;  o1_s5 <= xm_s4; o2_s5 <= m_s4;
			end
			3'd1: begin
				o0_s5 <= xm_s4; o1_s5 <= v_s4;  o2_s5 <= m_s4;
			end
			3'd2: begin
				o0_s5 <= m_s4;  o1_s5 <= v_s4;  o2_s5 <= xm_s4;
			end
			3'd3: begin
				o0_s5 <= m_s4;  o1_s5 <= xm_s4; o2_s5 <= v_s4;
			end
			3'd4: begin
				o0_s5 <= xm_s4; o1_s5 <= m_s4;  o2_s5 <= v_s4;
			end
			default: begin
				o0_s5 <= v_s4;  o1_s5 <= m_s4;  o2_s5 <= xm_s4;
			end
		endcase

		it_s6 <= it_s5;
		mx_s6 <= mx_s5;
		dz_s6 <= dz_s5;
		mz_s6 <= mz_s5;
		o0_s6 <= o0_s5;
		o1_s6 <= o1_s5;
		o2_s6 <= o2_s5;
	end

	// stage 7, output register
	always_ff @(posedge clk) begin
		req_s7 <= it_s6.req_type;
		result.out_alpha <= it_s6.in_alpha;
		case (it_s6.req_type)
			REQ_HSV2RGB: begin
				result.out_first  <= FIELD_W'(o0_s6);
				result.out_second <= FIELD_W'(o1_s6);
				result.out_third  <= FIELD_W'(o2_s6);
			end
			REQ_RGB2HSV: begin
				result.out_first  <= (dz_s6 || hq >= ONE) ? '0 : FIELD_W'(hq);
				result.out_second <= mz_s6 ? '0 : FIELD_W'(sq);
				result.out_third  <= FIELD_W'(mx_s6);
			end
			default: begin
				result.out_first  <= it_s6.in_first;
				result.out_second <= it_s6.in_second;
				result.out_third  <= it_s6.in_third;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	assign busy = 1'b0;
	assign done = vld_s7;

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##7 done) else $error("item result missing");
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 7)) else $error("result without item");
	a_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(done && req_s7 == REQ_RGB2HSV) |-> result.out_first < FIELD_W'(ONE))
		else $error("hue out of range");
	a_rgb: assert property (@(posedge clk) disable iff (!arst_n)
		(done && req_s7 == REQ_HSV2RGB) |-> (result.out_first <= FIELD_W'(ONE)
		&& result.out_second <= FIELD_W'(ONE) && result.out_third <= FIELD_W'(ONE)))
		else $error("rgb component above one");

endmodule
`default_nettype wire

### verif/rgb_hsv_color_converter_tb.sv
// Testbench for rgb_hsv_color_converter: drives pixel items with random gaps,
// predicts each converted color in Q1.15 and checks every done result in order.
// Depends on rhc_pkg and the converter RTL.
`default_nettype none
module rgb_hsv_color_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rhc_pkg::*;

	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int ONE_I = 1 << FRAC_BITS;

	class color_scoreboard;
		out_item_t pending[$];
		int mismatches = 0;

		function automatic logic [63:0] clamp1(logic [63:0] v);
			return (v > ONE_I) ? 64'(ONE_I) : v;
		endfunction

		function automatic logic [63:0] rdiv(logic [63:0] num, logic [63:0] den);
			return (2 * num + den) / (2 * den);
		endfunction

		function automatic out_item_t convert(in_item_t p);
			out_item_t o;
			logic [63:0] r, g, b, mx, mn, d, n, h, s, v, h6, sec, f, c, t, x, m, xm;
			o.out_alpha = p.in_alpha;
			if (p.req_type == REQ_RGB2HSV) begin
				r = clamp1(p.in_first);
				g = clamp1(p.in_second);
				b = clamp1(p.in_third);
				mx = (r > g) ? r : g;
				if (b > mx) mx = b;
				mn = (r < g) ? r : g;
				if (b < mn) mn = b;
				d = mx - mn;
				h = 0;
				if (d != 0) begin
					if (mx == r) n = (g >= b) ? g - b : 6 * d - (b - g);
					else if (mx == g) n = 2 * d + b - r;
					else n = 4 * d + r - g;
					h = rdiv(n * ONE_I, 6 * d);
					if (h >= ONE_I) h = 0;
				end
				o.out_first = h[15:0];
				o.out_second = (mx == 0) ? 16'd0 : 16'(rdiv(d * ONE_I, mx));
				o.out_third = mx[15:0];
			end else if (p.req_type == REQ_HSV2RGB) begin
				h = p.in_first & (ONE_I - 1);
				s = clamp1(p.in_second);
				v = clamp1(p.in_third);
				h6 = h * 6;
				sec = h6 >> FRAC_BITS;
				f = h6 & (ONE_I - 1);
				c = (v * s + (ONE_I >> 1)) >> FRAC_BITS;
				t = sec[0] ? ONE_I - f : f;
				x = (c * t + (ONE_I >> 1)) >> FRAC_BITS;
				m = v - c;
				xm = x + m;
				case (sec)
					0: {o.out_first, o.out_second, o.out_third} = {v[15:0], xm[15:0], m[15:0]};
					1: {o.out_first, o.out_second, o.out_third} = {xm[15:0], v[15:0], m[15:0]};
					2: {o.out_first, o.out_second, o.out_third} = {m[15:0], v[15:0], xm[15:0]};
					3: {o.out_first, o.out_second, o.out_third} = {m[15:0], xm[15:0], v[15:0]};
					4: {o.out_first, o.out_second, o.out_third} = {xm[15:0], m[15:0], v[15:0]};
					default: {o.out_first, o.out_second, o.out_third} = {v[15:0], m[15:0], xm[15:0]};
				endcase
			end else begin
				o.out_first = p.in_first;
				o.out_second = p.in_second;
				o.out_third = p.in_third;
			end
			return o;
		endfunction

		function void note_item(in_item_t p);
			pending.push_back(convert(p));
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.out_first !== want.out_first || got.out_second !== want.out_second ||
			    got.out_third !== want.out_third || got.out_alpha !== want.out_alpha) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h %h %h %h, got %h %h %h %h",
						want.out_first, want.out_second, want.out_third, want.out_alpha,
						got.out_first, got.out_second, got.out_third, got.out_alpha);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	in_item_t pixel = '0;
	out_item_t result;
	color_scoreboard sb = new();
	bit gaps_on = 1'b1;

	rgb_hsv_color_converter dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel(pixel), .done(done), .result(result)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	function automatic logic [15:0] rand_comp();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return 16'($urandom);
		if (k == 1) return 16'(ONE_I);
		if (k == 2) return 16'd0;
		return 16'($urandom_range(0, ONE_I));
	endfunction

	task automatic send_item(logic [1:0] rq, logic [15:0] a, logic [15:0] b,
	                         logic [15:0] c, logic [15:0] al);
		in_item_t p;
		int n;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			n = $urandom_range(1, 16);
			repeat (n) @(posedge clk);
		end
		p.req_type = rq;
		p.in_first = a;
		p.in_second = b;
		p.in_third = c;
		p.in_alpha = al;
		start <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (busy);
		sb.note_item(p);
	endtask

	task automatic send_random();
		logic [1:0] rq;
		int k;
		k = $urandom_range(0, 19);
		rq = (k == 0) ? REQ_SPARE : (k < 4) ? REQ_PASS : (k < 12) ? REQ_HSV2RGB : REQ_RGB2HSV;
		send_item(rq, rand_comp(), rand_comp(), rand_comp(), 16'($urandom));
	endtask

	initial begin
		int wait_cyc;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_item(REQ_PASS, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
		send_item(REQ_PASS, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
		send_item(REQ_SPARE, 16'h1234, 16'hFFFF, 16'h8000, 16'h8000);
		send_item(REQ_RGB2HSV, 16'd0, 16'd0, 16'd0, 16'd0);
		send_item(REQ_RGB2HSV, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(REQ_RGB2HSV, 16'h8000, 16'h0000, 16'h0000, 16'h8000);
		send_item(REQ_RGB2HSV, 16'h0000, 16'h8000, 16'h0000, 16'h1);
		send_item(REQ_RGB2HSV, 16'h0000, 16'h0000, 16'h8000, 16'h2);
		send_item(REQ_RGB2HSV, 16'h8000, 16'h0000, 16'h0001, 16'h3);
		send_item(REQ_RGB2HSV, 16'h8000, 16'h8000, 16'h0000, 16'h4);
		send_item(REQ_RGB2HSV, 16'h4000, 16'h4000, 16'h4000, 16'h5);
		send_item(REQ_RGB2HSV, 16'hC000, 16'h0000, 16'h9000, 16'h6);
		send_item(REQ_HSV2RGB, 16'h0000, 16'h8000, 16'h8000, 16'h7);
		send_item(REQ_HSV2RGB, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8);
		send_item(REQ_HSV2RGB, 16'h7FFF, 16'h8000, 16'h8000, 16'h9);
		send_item(REQ_HSV2RGB, 16'h8000, 16'h0000, 16'h8000, 16'hA);
		for (int i = 0; i < 6; i++)
			send_item(REQ_HSV2RGB, 16'(i * ONE_I / 6 + 100), 16'h6000, 16'h7000, 16'(i));
		for (int i = 0; i < 1030; i++) begin
			if (i == 900) gaps_on = 1'b0;
			send_random();
		end
		start <= 1'b0;
		wait_cyc = 0;
		while (sb.pending.size() != 0 && wait_cyc < 1000) begin
			@(posedge clk);
			wait_cyc++;
		end
		repeat (20) @(posedge clk);
		if (sb.pending.size() == 0 && sb.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
